/* rtl/core/dsrt_pkg.sv */
// dsrt_pkg: shared types, codes and widths for the date sorted record table
// used by dsrt_cell and date_sorted_record_table_core; no dependencies
`timescale 1ns / 1ps

package dsrt_pkg;

  // field widths
  localparam int ID_W     = 27;
  localparam int DATE_W   = 24;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;

  // default table size
  localparam int DSRT_CAPACITY = 64;

  // command codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE     = 2'd1,
    OP_QUERY_ID   = 2'd2,
    OP_QUERY_DATE = 2'd3
  } op_t;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  // one record
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DATE_W-1:0] date;
  } entry_t;

  // update control broadcast to every cell
  typedef struct packed {
    logic upd;
    op_t  op;
  } cell_ctl_t;

endpackage

/* rtl/core/date_sorted_record_table_core.sv */
// date_sorted_record_table_core: top level, row of dsrt_cell slots plus control
// depends on dsrt_pkg and dsrt_cell
`timescale 1ns / 1ps

// A table of up to CAPACITY records kept in ascending date order in a row of
// cells, one record per cell. Every word has an accept step and an update step:
// on acceptance each cell compares its record against the incoming word and
// stores the flags; in the update step the cells shift toward or away from the
// insert or remove point in one step and the result word is registered.
// in_ready is low from acceptance until the update, so no new word is taken
// before the last is applied; the update waits while an earlier result still
// sits unread in the output register. Inserts into a full table and removes
// of an absent identity leave the table unchanged and report it in out_status.

module date_sorted_record_table_core import dsrt_pkg::*; #(
  parameter int CAPACITY = DSRT_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [ID_W-1:0]     in_entry_id,
  input  logic [DATE_W-1:0]   in_date_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_hit,
  output logic [FILL_W-1:0]   out_fill
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                phase_r;
  op_t                 cmd_op_r;
  entry_t              cmd_ent_r;
  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic                hit_r;
  logic                hit_nxt;

  logic                cap_en;
  logic                fire;
  logic                full;
  logic                any_id;
  logic                any_date;
  entry_t              key;
  cell_ctl_t           ctl;

  entry_t              ent_vec [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] idm_vec;
  logic [CAPACITY-1:0] dm_vec;
  logic [CAPACITY-1:0] pre_vec;

  assign in_ready = !phase_r;
  assign cap_en   = in_valid && in_ready;
  assign fire     = phase_r && (!out_valid_r || out_ready);
  assign key.id   = in_entry_id;
  assign key.date = in_date_key;

  // row of cells with neighbor links and first-match prefix
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic   ge_left;
    entry_t left_ent;
    entry_t right_ent;

    assign valid_vec[k] = CNT_W'(k) < count_r;
    assign pre_vec[k]   = |idm_vec[k:0];

    if (k == 0) begin : g_first
      assign ge_left  = 1'b0;
      assign left_ent = cmd_ent_r;
    end else begin : g_mid
      assign ge_left  = ge_vec[k-1];
      assign left_ent = ent_vec[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right_ent = ent_vec[k];
    end else begin : g_body
      assign right_ent = ent_vec[k+1];
    end

    dsrt_cell u_cell (
      .clk         (clk),
      .cap_en_i    (cap_en),
      .valid_i     (valid_vec[k]),
      .key_i       (key),
      .ctl_i       (ctl),
      .ge_left_i   (ge_left),
      .pre_match_i (pre_vec[k]),
      .left_i      (left_ent),
      .right_i     (right_ent),
      .new_i       (cmd_ent_r),
      .ent_o       (ent_vec[k]),
      .ge_o        (ge_vec[k]),
      .idm_o       (idm_vec[k]),
      .dm_o        (dm_vec[k])
    );
  end

  assign full     = count_r == CNT_W'(CAPACITY);
  assign any_id   = |idm_vec;
  assign any_date = |dm_vec;

  // result and table update decision
  always_comb begin
    ctl.op     = cmd_op_r;
    ctl.upd    = 1'b0;
    status_nxt = ST_DONE;
    hit_nxt    = 1'b0;
    count_nxt  = count_r;
    case (cmd_op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.upd   = fire;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!any_id) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          ctl.upd   = fire;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_QUERY_ID:   hit_nxt = any_id;
      OP_QUERY_DATE: hit_nxt = any_date;
      default:       hit_nxt = 1'b0;
    endcase
  end

  // command latch
  always_ff @(posedge clk) begin
    if (cap_en) begin
      cmd_op_r  <= op_t'(in_op);
      cmd_ent_r <= key;
    end
  end

  // control, fill count and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cap_en) begin
        phase_r <= 1'b1;
      end else if (fire) begin
        phase_r <= 1'b0;
      end
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      hit_r    <= hit_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_hit    = hit_r;
  assign out_fill   = FILL_W'(count_r);

endmodule

/* rtl/core/dsrt_cell.sv */
// dsrt_cell: one slot of the sorted table, holds a record and its compare flags
// depends on dsrt_pkg
`timescale 1ns / 1ps

module dsrt_cell import dsrt_pkg::*; (
  input  logic      clk,
  input  logic      cap_en_i,
  input  logic      valid_i,
  input  entry_t    key_i,
  input  cell_ctl_t ctl_i,
  input  logic      ge_left_i,
  input  logic      pre_match_i,
  input  entry_t    left_i,
  input  entry_t    right_i,
  input  entry_t    new_i,
  output entry_t    ent_o,
  output logic      ge_o,
  output logic      idm_o,
  output logic      dm_o
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   ge_r;
  logic   idm_r;
  logic   dm_r;

  // compare flags captured when a word is accepted
  always_ff @(posedge clk) begin
    if (cap_en_i) begin
      ge_r  <= !valid_i || (ent_r.date >= key_i.date);
      idm_r <= valid_i && (ent_r.id == key_i.id);
      dm_r  <= valid_i && (ent_r.date == key_i.date);
    end
  end

  // next content: keep, take new record, take from left or right neighbor
  always_comb begin
    ent_nxt = ent_r;
    case (ctl_i.op)
      OP_INSERT: begin
        if (ge_r) begin
          ent_nxt = ge_left_i ? left_i : new_i;
        end
      end
      OP_REMOVE: begin
        if (pre_match_i) begin
          ent_nxt = right_i;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl_i.upd) begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;
  assign ge_o  = ge_r;
  assign idm_o = idm_r;
  assign dm_o  = dm_r;

endmodule
